// ----- hdl/pngg_pkg.sv -----
// ----------------------------------------------------------------------------
// pngg_pkg
// Shared types, codes and scaling helpers of the row-to-gray8 converter.
// ----------------------------------------------------------------------------
package pngg_pkg;

    // source pixel format codes (code 7 is unused and acts as gray8)
    typedef enum logic [2:0] {
        MODE_GRAY8  = 3'd0,
        MODE_GRAY1  = 3'd1,
        MODE_GRAY2  = 3'd2,
        MODE_GRAY4  = 3'd3,
        MODE_GRAY16 = 3'd4,
        MODE_GA     = 3'd5,
        MODE_RGB565 = 3'd6
    } t_mode;

    // how the back end unpacks one queue entry
    typedef enum logic [1:0] {
        PK_NONE = 2'd0,
        PK_1    = 2'd1,
        PK_2    = 2'd2,
        PK_4    = 2'd3
    } t_pack;

    typedef struct packed {
        t_pack       pack;
        logic [7:0]  data;
    } t_entry;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] level;
    } t_q_status;

    localparam logic [1:0] REG_PIXEL_MODE = 2'd0;
    localparam logic [1:0] REG_ROW_WIDTH  = 2'd1;

    // v * 255 / 31, as 8v + floor(7v / 31)
    function automatic logic [7:0] scale5(input logic [4:0] v);
        logic [2:0] f;
        f = 3'd0;
        if (v >= 5'd5)  f = 3'd1;
        if (v >= 5'd9)  f = 3'd2;
        if (v >= 5'd14) f = 3'd3;
        if (v >= 5'd18) f = 3'd4;
        if (v >= 5'd23) f = 3'd5;
        if (v >= 5'd27) f = 3'd6;
        if (v >= 5'd31) f = 3'd7;
        return {v, 3'b000} + 8'(f);
    endfunction

    // v * 255 / 63, as 4v + floor(v / 21)
    function automatic logic [7:0] scale6(input logic [5:0] v);
        logic [1:0] f;
        f = 2'd0;
        if (v >= 6'd21) f = 2'd1;
        if (v >= 6'd42) f = 2'd2;
        if (v >= 6'd63) f = 2'd3;
        return {v, 2'b00} + 8'(f);
    endfunction

endpackage

// ----- hdl/png_row_to_gray8_converter.sv -----
// ----------------------------------------------------------------------------
// png_row_to_gray8_converter
// An item passes front stages 1 and 2, the queue, the back-end byte register
// and the output register. Throughput: 1 item per cycle in single-pixel modes
// unless stalled; packed gray items give 8, 4 or 2 pixels (fewer at a row end).
// Reset (synchronous, active low) empties the pipeline and queue, clears the
// column count and sets pixel_mode to gray8 and row_width to 1600.
// ----------------------------------------------------------------------------
module png_row_to_gray8_converter import pngg_pkg::*; #(
    parameter int MAX_ROW_WIDTH = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,    // [15:0] sample
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,    // [7:0] gray
    output logic        o_m_axis_tuser,    // [0] last_of_item
    output logic        o_m_axis_tlast,    // row_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0]  r_pixel_mode;
    logic [11:0] r_row_width;

    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    logic        push;
    logic        pop;
    t_entry      front_entry;
    t_entry      queue_entry;
    t_q_status   q_status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = {1'b0, paddr[2]};

    always_comb begin
        case (cfg_idx)
            REG_ROW_WIDTH: prdata = {20'd0, r_row_width};
            default:       prdata = {29'd0, r_pixel_mode};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_mode <= MODE_GRAY8;
            r_row_width  <= 12'd1600;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_PIXEL_MODE: r_pixel_mode <= pwdata[2:0];
                REG_ROW_WIDTH:  r_row_width  <= pwdata[11:0];
                default:        r_pixel_mode <= r_pixel_mode;
            endcase
        end
    end

    pngg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_mode     (r_pixel_mode),
        .o_push     (push),
        .o_entry    (front_entry),
        .i_q_full   (q_status.full)
    );

    pngg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (front_entry),
        .i_pop    (pop),
        .o_entry  (queue_entry),
        .o_status (q_status)
    );

    pngg_back #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (queue_entry),
        .i_q_empty   (q_status.empty),
        .o_pop       (pop),
        .i_row_width (r_row_width),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tuser   (o_m_axis_tuser),
        .o_m_tlast   (o_m_axis_tlast)
    );

    // a pixel that ends the row always ends its item
    a_row_end_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser)
        else $error("row end without item end");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.level <= QCNT_W'(QDEPTH))
        else $error("queue level above depth");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.empty |-> !pop)
        else $error("back end popped an empty queue");

endmodule

// ----- hdl/pngg_front.sv -----
// ----------------------------------------------------------------------------
// pngg_front
// Accepts source samples, classifies them by pixel mode and passes all
// through two register stages to the queue, converting single-pixel formats.
// ----------------------------------------------------------------------------
module pngg_front import pngg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,     // [15:0] sample
    input  logic [2:0]  i_mode,
    output logic        o_push,
    output t_entry      o_entry,
    input  logic        i_q_full
);

    logic        r_s1_valid;
    t_mode       r_s1_mode;
    logic [7:0]  r_s1_byte;
    logic [15:0] r_s1_x;
    logic [7:0]  r_s1_r;
    logic [7:0]  r_s1_g;
    logic [7:0]  r_s1_b;

    logic        r_s2_valid;
    t_entry      r_s2;

    logic        s1_take;
    logic        s2_take;
    t_mode       in_mode;
    logic [7:0]  n_s1_byte;
    logic [15:0] ga_prod;
    logic [7:0]  na;
    logic [16:0] blend_x;
    logic [16:0] div_sum;
    logic [15:0] wsum;
    t_entry      n_s2;

    assign s2_take    = !r_s2_valid || !i_q_full;
    assign s1_take    = !r_s1_valid || s2_take;
    assign o_s_tready = s1_take;
    assign o_push     = r_s2_valid;
    assign o_entry    = r_s2;
    assign in_mode    = t_mode'(i_mode);

    always_comb begin
        n_s1_byte = (in_mode == MODE_GRAY16) ? i_s_tdata[15:8] : i_s_tdata[7:0];
        // g*a + 255*(255-a), always below 65026
        ga_prod   = 16'(i_s_tdata[15:8]) * 16'(i_s_tdata[7:0]);
        na        = ~i_s_tdata[7:0];
        blend_x   = 17'(ga_prod) + {1'b0, na, 8'h00} - 17'(na);
    end

    always_comb begin
        // exact x/255 for x below 65535
        div_sum = 17'(r_s1_x) + 17'(r_s1_x[15:8]) + 17'd1;
        wsum    = 16'(r_s1_r) * 16'd77 + 16'(r_s1_g) * 16'd151 + 16'(r_s1_b) * 16'd28;
        n_s2.pack = PK_NONE;
        n_s2.data = r_s1_byte;
        unique case (r_s1_mode)
            MODE_GRAY1:  n_s2.pack = PK_1;
            MODE_GRAY2:  n_s2.pack = PK_2;
            MODE_GRAY4:  n_s2.pack = PK_4;
            MODE_GA:     n_s2.data = div_sum[15:8];
            MODE_RGB565: n_s2.data = wsum[15:8];
            default:     n_s2.pack = PK_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_take) begin
                r_s1_valid <= i_s_tvalid;
            end
            if (s2_take) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take && i_s_tvalid) begin
            r_s1_mode <= in_mode;
            r_s1_byte <= n_s1_byte;
            r_s1_x    <= blend_x[15:0];
            r_s1_r    <= scale5(i_s_tdata[15:11]);
            r_s1_g    <= scale6(i_s_tdata[10:5]);
            r_s1_b    <= scale5(i_s_tdata[4:0]);
        end
        if (s2_take && r_s1_valid) begin
            r_s2 <= n_s2;
        end
    end

endmodule

// ----- hdl/pngg_queue.sv -----
// ----------------------------------------------------------------------------
// pngg_queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module pngg_queue import pngg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output t_entry    o_entry,
    output t_q_status o_status
);

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_status.level = r_count;
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ----- hdl/pngg_back.sv -----
// ----------------------------------------------------------------------------
// pngg_back
// Unpacks queued entries into gray pixels, one per cycle unless the output
// is stalled, tracks the column and drives the output register.
// ----------------------------------------------------------------------------
module pngg_back import pngg_pkg::*; #(
    parameter int MAX_ROW_WIDTH = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_entry,
    input  logic        i_q_empty,
    output logic        o_pop,
    input  logic [11:0] i_row_width,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,     // [7:0] gray
    output logic        o_m_tuser,     // [0] last_of_item
    output logic        o_m_tlast      // row_end
);

    localparam int CNT_W = $clog2(MAX_ROW_WIDTH);
    localparam int WW_MIN = $clog2(MAX_ROW_WIDTH + 1);
    localparam int WW = (WW_MIN > 12) ? WW_MIN : 12;

    logic             r_busy;
    logic             r_ov;
    logic [CNT_W-1:0] r_col;
    logic [3:0]       r_left;
    logic [7:0]       r_byte;
    t_pack            r_pack;
    logic [7:0]       r_gray;
    logic             r_item_last;
    logic             r_row_end;

    logic          emit;
    logic          load;
    logic          is_end;
    logic          is_last;
    logic [WW-1:0] eff_w;
    logic [WW-1:0] col_next;
    logic [7:0]    pix;
    logic [7:0]    n_byte;
    logic [3:0]    n_left;

    always_comb begin
        if (i_row_width == 12'd0) begin
            eff_w = WW'(1);
        end else if (WW'(i_row_width) > WW'(MAX_ROW_WIDTH)) begin
            eff_w = WW'(MAX_ROW_WIDTH);
        end else begin
            eff_w = WW'(i_row_width);
        end
        col_next = WW'(r_col) + WW'(1);
        is_end   = (col_next >= eff_w);
        is_last  = is_end || (r_left == 4'd1);
        emit     = r_busy && (!r_ov || i_m_tready);
        load     = !i_q_empty && (!r_busy || (emit && is_last));
    end

    always_comb begin
        case (r_pack)
            PK_1: begin
                pix    = {8{r_byte[7]}};
                n_byte = {r_byte[6:0], 1'b0};
            end
            PK_2: begin
                pix    = {4{r_byte[7:6]}};
                n_byte = {r_byte[5:0], 2'b00};
            end
            PK_4: begin
                pix    = {2{r_byte[7:4]}};
                n_byte = {r_byte[3:0], 4'b0000};
            end
            default: begin
                pix    = r_byte;
                n_byte = r_byte;
            end
        endcase
        case (i_entry.pack)
            PK_1:    n_left = 4'd8;
            PK_2:    n_left = 4'd4;
            PK_4:    n_left = 4'd2;
            default: n_left = 4'd1;
        endcase
    end

    assign o_pop      = load;
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_gray;
    assign o_m_tuser  = r_item_last;
    assign o_m_tlast  = r_row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_col  <= '0;
            r_left <= '0;
        end else begin
            if (emit) begin
                r_ov  <= 1'b1;
                r_col <= is_end ? '0 : CNT_W'(col_next);
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
            if (load) begin
                r_busy <= 1'b1;
                r_left <= n_left;
            end else if (emit) begin
                // drop the rest of a packed byte once the row ends
                if (is_last) begin
                    r_busy <= 1'b0;
                end
                r_left <= r_left - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_entry.data;
            r_pack <= i_entry.pack;
        end else if (emit) begin
            r_byte <= n_byte;
        end
        if (emit) begin
            r_gray      <= pix;
            r_item_last <= is_last;
            r_row_end   <= is_end;
        end
    end

endmodule
